### rtl/kmeans_gray_quantizer_assert.svh
// Assertion macros shared by the checker of the gray-level quantizer.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef KMEANS_GRAY_QUANTIZER_ASSERT_SVH
`define KMEANS_GRAY_QUANTIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KGQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KGQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/kgq_pkg.sv
// Package of the gray-level k-means quantizer: sizes, command codes and types.
// Used by the cell, the top level and the checker.
package kgq_pkg;

    localparam int NUM_CLUSTERS   = 6;
    localparam int COUNT_BITS     = 20;
    localparam int MEAN_FRAC_BITS = 8;
    localparam int NUM_INIT_REGS  = 6;

    localparam int PIX_W     = 8;
    localparam int CLUSTER_W = 3;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int MEAN_W    = PIX_W + MEAN_FRAC_BITS;
    localparam int SUM_W     = COUNT_BITS + PIX_W;
    localparam int STEP_W    = $clog2(MEAN_W);

    localparam logic [CMD_W-1:0] CMD_TRAIN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUANT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELOAD = 2'd2;

    localparam logic [PIX_W-1:0] INIT_RESET [NUM_INIT_REGS] =
        '{8'd0, 8'd65, 8'd100, 8'd125, 8'd190, 8'd255};
    localparam logic [PIX_W-1:0] INIT_NO_REG = 8'd255;

    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [PIX_W-1:0]     pixel;
        logic [MEAN_W-1:0]    delta;
        logic [CLUSTER_W-1:0] idx;
        logic [MEAN_W-1:0]    mean;
    } search_t;

    typedef struct packed {
        logic                 acc;
        logic [CLUSTER_W-1:0] acc_idx;
        logic [PIX_W-1:0]     acc_pixel;
        logic                 reload;
        logic                 div_load;
        logic                 div_step;
        logic                 div_end;
    } cell_ctl_t;

endpackage

### rtl/kgq_cell.sv
// One cluster of the quantizer: its mean, sum and count, one stage of the
// nearest-mean search chain, and a bit-serial divider for the mean update.
// Depends on kgq_pkg.
module kgq_cell
    import kgq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cell_ctl_t            ctl,
    input  logic [CLUSTER_W-1:0] cell_idx,
    input  logic [PIX_W-1:0]     init_mean,
    input  search_t              search_in,
    output search_t              search_out
);

    logic [MEAN_W-1:0]     mean_reg;
    logic [MEAN_W-1:0]     mean_next;
    logic [SUM_W-1:0]      sum_reg;
    logic [SUM_W-1:0]      sum_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] rem_next;
    logic [MEAN_W-1:0]     low_reg;
    logic [MEAN_W-1:0]     low_next;
    logic [MEAN_W-1:0]     quo_reg;
    logic [MEAN_W-1:0]     quo_next;
    search_t               search_reg;
    search_t               search_next;

    logic [MEAN_W-1:0]     target;
    logic [MEAN_W-1:0]     dist_now;
    logic [COUNT_BITS:0]   trial;
    logic [COUNT_BITS:0]   diff;
    logic                  fits;

    always_comb
    begin
        target   = MEAN_W'(search_in.pixel) << MEAN_FRAC_BITS;
        dist_now = (target >= mean_reg) ? target - mean_reg : mean_reg - target;
        search_next = search_in;
        search_next.found = 1'b1;
        if (!search_in.found || dist_now < search_in.delta)
        begin
            search_next.delta = dist_now;
            search_next.idx   = cell_idx;
            search_next.mean  = mean_reg;
        end
    end

    always_comb
    begin
        trial = {rem_reg, low_reg[MEAN_W-1]};
        diff  = trial - {1'b0, count_reg};
        fits  = trial >= {1'b0, count_reg};

        mean_next  = mean_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        quo_next   = quo_reg;

        if (ctl.reload)
        begin
            mean_next  = MEAN_W'(init_mean) << MEAN_FRAC_BITS;
            sum_next   = '0;
            count_next = '0;
        end
        else if (ctl.acc)
        begin
            if (ctl.acc_idx == cell_idx && count_reg != '1)
            begin
                sum_next   = sum_reg + SUM_W'(ctl.acc_pixel);
                count_next = count_reg + 1'b1;
            end
        end
        else if (ctl.div_load)
        begin
            rem_next = sum_reg[SUM_W-1:PIX_W];
            low_next = MEAN_W'(sum_reg[PIX_W-1:0]) << MEAN_FRAC_BITS;
            quo_next = '0;
        end
        else if (ctl.div_step)
        begin
            rem_next = fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            low_next = low_reg << 1;
            quo_next = {quo_reg[MEAN_W-2:0], fits};
        end
        else if (ctl.div_end)
        begin
            if (count_reg != '0)
            begin
                mean_next = quo_reg;
            end
            sum_next   = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg  <= mean_next;
        sum_reg   <= sum_next;
        count_reg <= count_next;
        rem_reg   <= rem_next;
        low_reg   <= low_next;
        quo_reg   <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_reg <= '0;
        end
        else
        begin
            search_reg <= search_next;
        end
    end

    assign search_out = search_reg;

endmodule

### rtl/kmeans_gray_quantizer.sv
// Gray-level k-means quantizer with six clusters.
// Top level: control sequencer, configuration registers and the row of kgq_cell.
// Depends on kgq_pkg and kgq_cell.
//
// Each pixel item is matched against the six cluster means by a search token
// that walks the row of cells one cell per cycle; the block takes no new item
// until the walk and the control and commit steps are done. The last pixel of
// a train pass is followed by the load, divide and end states of the
// bit-serial dividers in the cells, which produce sixteen quotient bits, one
// per cycle. After reset the block loads the means from the configuration
// registers in its init state before it takes the first item. A finished
// result sits in an output register and the next item is taken while it waits.
module kmeans_gray_quantizer
    import kgq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     command,
    input  logic [PIX_W-1:0]     pixel,
    input  logic                 last_of_pass,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CLUSTER_W-1:0] cluster,
    output logic [PIX_W-1:0]     level,
    output logic                 means_updated,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [PIX_W-1:0]     cfg_data
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SEARCH = 3'd2;
    localparam logic [2:0] ST_DONE   = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_END    = 3'd6;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [CMD_W-1:0]     cmd_next;
    logic                 last_reg;
    logic                 last_next;
    logic [PIX_W-1:0]     pixel_reg;
    logic [PIX_W-1:0]     pixel_next;
    logic [CLUSTER_W-1:0] res_idx_reg;
    logic [CLUSTER_W-1:0] res_idx_next;
    logic [MEAN_W-1:0]    res_mean_reg;
    logic [MEAN_W-1:0]    res_mean_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CLUSTER_W-1:0] out_cluster_reg;
    logic [CLUSTER_W-1:0] out_cluster_next;
    logic [PIX_W-1:0]     out_level_reg;
    logic [PIX_W-1:0]     out_level_next;
    logic                 out_upd_reg;
    logic                 out_upd_next;
    logic [PIX_W-1:0]     init_reg [NUM_INIT_REGS];

    logic                 accept;
    logic                 out_free;
    logic                 close_pass;
    cell_ctl_t            ctl;
    search_t              chain [NUM_CLUSTERS+1];
    logic [PIX_W-1:0]     init_mean [NUM_CLUSTERS];

    assign accept     = in_valid && (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign close_pass = (cmd_reg == CMD_TRAIN) && last_reg;

    always_comb
    begin
        chain[0]       = '0;
        chain[0].valid = accept;
        chain[0].pixel = pixel;
    end

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        cmd_next         = cmd_reg;
        last_next        = last_reg;
        pixel_next       = pixel_reg;
        res_idx_next     = res_idx_reg;
        res_mean_next    = res_mean_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_cluster_next = out_cluster_reg;
        out_level_next   = out_level_reg;
        out_upd_next     = out_upd_reg;
        ctl              = '0;
        ctl.acc_idx      = res_idx_reg;
        ctl.acc_pixel    = pixel_reg;

        case (state_reg)
            ST_INIT:
            begin
                ctl.reload = 1'b1;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = command;
                    last_next  = last_of_pass;
                    pixel_next = pixel;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (chain[NUM_CLUSTERS].valid)
                begin
                    res_idx_next  = chain[NUM_CLUSTERS].idx;
                    res_mean_next = chain[NUM_CLUSTERS].mean;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_cluster_next = res_idx_reg;
                    out_level_next   = res_mean_reg[MEAN_W-1 -: PIX_W];
                    out_upd_next     = close_pass;
                    ctl.acc          = (cmd_reg == CMD_TRAIN);
                    ctl.reload       = (cmd_reg == CMD_RELOAD);
                    state_next       = close_pass ? ST_LOAD : ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                ctl.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                ctl.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(MEAN_W - 1))
                begin
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                ctl.div_end = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_INIT_REGS; i++)
            begin
                init_reg[i] <= INIT_RESET[i];
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < NUM_INIT_REGS; i++)
            begin
                if (cfg_we && cfg_index == CFG_IDX_W'(i))
                begin
                    init_reg[i] <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg        <= step_next;
        cmd_reg         <= cmd_next;
        last_reg        <= last_next;
        pixel_reg       <= pixel_next;
        res_idx_reg     <= res_idx_next;
        res_mean_reg    <= res_mean_next;
        out_cluster_reg <= out_cluster_next;
        out_level_reg   <= out_level_next;
        out_upd_reg     <= out_upd_next;
    end

    for (genvar i = 0; i < NUM_CLUSTERS; i++)
    begin : g_cells
        if (i < NUM_INIT_REGS)
        begin : g_reg
            assign init_mean[i] = init_reg[i];
        end
        else
        begin : g_fixed
            assign init_mean[i] = INIT_NO_REG;
        end

        kgq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .cell_idx   (CLUSTER_W'(i)),
            .init_mean  (init_mean[i]),
            .search_in  (chain[i]),
            .search_out (chain[i+1])
        );
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign cluster       = out_cluster_reg;
    assign level         = out_level_reg;
    assign means_updated = out_upd_reg;

endmodule

### rtl/kgq_checker.sv
// Port-level checker of the gray-level quantizer, bound to the top level.
// Depends on kgq_pkg and kmeans_gray_quantizer_assert.svh.
`include "kmeans_gray_quantizer_assert.svh"

module kgq_checker
    import kgq_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [CLUSTER_W-1:0] cluster,
    input logic                 means_updated
);

    `KGQ_ASSERT_NEXT(a_out_held, out_valid && out_stall, out_valid, "result item dropped while stalled")
    `KGQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second item taken while busy")
    `KGQ_ASSERT_NOW(a_cluster_range, out_valid, cluster <= CLUSTER_W'(NUM_CLUSTERS - 1), "cluster index out of range")
    `KGQ_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall), "result item without a taken item")
    `KGQ_ASSERT_NEXT(a_update_stalls, $rose(out_valid) && means_updated, in_stall, "input open during mean update")

endmodule

bind kmeans_gray_quantizer kgq_checker u_kgq_checker (.*);
